// ===== design/frsp_pkg.sv =====
// Shared types, constants and item builders for the FASTQ record stream parser.
package frsp_pkg;

  localparam int NAME_BYTES  = 256;
  localparam int LENGTH_BITS = 24;
  localparam int NAME_AW     = $clog2(NAME_BYTES);
  localparam int NC_W        = $clog2(NAME_BYTES + 1);
  localparam int RC_W        = $clog2(NAME_BYTES + 2);
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_PW      = $clog2(OUT_DEPTH);
  localparam int OUT_CW      = $clog2(OUT_DEPTH + 1);

  localparam logic [7:0] CHAR_AT   = 8'h40;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [6:0] CHAR_CR7  = CHAR_CR[6:0];

  typedef enum logic [2:0] {
    KIND_NAME,
    KIND_SEQ,
    KIND_QUAL,
    KIND_REC_END,
    KIND_STREAM_END
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_NO_AT,
    ERR_NO_PLUS,
    ERR_HDR_MISMATCH,
    ERR_LEN_MISMATCH,
    ERR_PREMATURE_END,
    ERR_NON_ASCII,
    ERR_CAPACITY
  } err_e;

  typedef struct packed {
    kind_e                  kind;
    logic [6:0]             payload;
    logic [LENGTH_BITS-1:0] seq_len;
    logic                   hdr;
    err_e                   err;
  } item_t;

  typedef struct packed {
    logic [1:0] cnt;
    item_t      item0;
    item_t      item1;
    logic       cmp_en;
    logic [6:0] cmp_byte;
    logic       cmp_ok;
    logic       probe_en;
    logic       probe_ok;
    logic       use_cr;
    logic       chk_hdr;
    logic       hdr_rep;
    logic       hdr_len_bad;
    logic       clr_mis;
  } plan_t;

  typedef struct packed {
    logic               we;
    logic [NAME_AW-1:0] waddr;
    logic [6:0]         wdata;
    logic               re;
    logic [NAME_AW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic  two;
    item_t item0;
    item_t item1;
  } entry_t;

  function automatic item_t byte_item(kind_e k, logic [6:0] b);
    item_t it;
    it         = '0;
    it.kind    = k;
    it.payload = b;
    it.err     = ERR_NONE;
    return it;
  endfunction

  function automatic item_t end_item(err_e e);
    item_t it;
    it      = '0;
    it.kind = KIND_STREAM_END;
    it.err  = e;
    return it;
  endfunction

  function automatic item_t rec_item(logic [LENGTH_BITS-1:0] len, logic hdr);
    item_t it;
    it         = '0;
    it.kind    = KIND_REC_END;
    it.seq_len = len;
    it.hdr     = hdr;
    it.err     = ERR_NONE;
    return it;
  endfunction

endpackage

// ===== design/frsp_name_ram.sv =====
// Record name store: one write port, one registered read port.
module frsp_name_ram
  import frsp_pkg::*;
(
  input  logic       clk_i,
  input  ram_req_t   req_i,
  output logic [6:0] rdata_o
);

  logic [6:0] mem [NAME_BYTES];
  logic [6:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/frsp_parse.sv =====
// Line walker: tracks record phase and counters, plans results and name store accesses.
module frsp_parse
  import frsp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_file_i,
  output ram_req_t   ram_req_o,
  output logic       s1_valid_o,
  output plan_t      plan_o
);

  typedef enum logic [1:0] {
    PH_NAME,
    PH_SEQ,
    PH_PLUS,
    PH_QUAL
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic                   start_q, start_d;
  logic                   held_q, held_d;
  logic [NC_W-1:0]        nc_q, nc_d;
  logic [RC_W-1:0]        rc_q, rc_d;
  logic [LENGTH_BITS-1:0] seq_q, seq_d;
  logic [LENGTH_BITS-1:0] qual_q, qual_d;
  err_e                   err_q, err_d;
  logic                   s1_valid_q;
  plan_t                  plan_q, pl;
  ram_req_t               req;
  logic                   accept;
  logic                   go, stop, qfin, act;
  logic [6:0]             c7, ch;

  function automatic plan_t add_item(plan_t p, item_t it);
    plan_t r;
    r = p;
    if (r.cnt == 2'd0) begin
      r.item0 = it;
    end else begin
      r.item1 = it;
    end
    r.cnt = r.cnt + 2'd1;
    return r;
  endfunction

  assign accept = in_valid_i & ~in_stall_i;
  assign c7     = data_byte_i[6:0];

  always_comb begin
    phase_d = phase_q;
    start_d = start_q;
    held_d  = held_q;
    nc_d    = nc_q;
    rc_d    = rc_q;
    seq_d   = seq_q;
    qual_d  = qual_q;
    err_d   = err_q;
    pl      = '0;
    req     = '0;
    go      = 1'b0;
    stop    = 1'b0;
    qfin    = 1'b0;
    act     = 1'b0;
    ch      = '0;
    if (err_q != ERR_NONE) begin
      pl = add_item(pl, end_item(err_q));
    end else if (end_of_file_i) begin
      held_d = 1'b0;
      if (phase_q == PH_QUAL && !start_q) begin
        qfin = 1'b1;
      end else if (phase_q == PH_NAME && start_q) begin
        pl = add_item(pl, end_item(ERR_NONE));
      end else begin
        err_d = ERR_PREMATURE_END;
        pl    = add_item(pl, end_item(ERR_PREMATURE_END));
      end
    end else if (data_byte_i[7]) begin
      held_d = 1'b0;
      err_d  = ERR_NON_ASCII;
      pl     = add_item(pl, end_item(ERR_NON_ASCII));
    end else if (data_byte_i == CHAR_LF) begin
      held_d  = 1'b0;
      start_d = 1'b1;
      case (phase_q)
        PH_NAME: begin
          if (start_q) begin
            err_d = ERR_NO_AT;
            pl    = add_item(pl, end_item(ERR_NO_AT));
          end else begin
            phase_d = PH_SEQ;
          end
        end
        PH_SEQ: begin
          phase_d = PH_PLUS;
        end
        PH_PLUS: begin
          if (start_q) begin
            err_d = ERR_NO_PLUS;
            pl    = add_item(pl, end_item(ERR_NO_PLUS));
          end else begin
            pl.chk_hdr     = 1'b1;
            pl.hdr_rep     = (rc_q != '0);
            pl.hdr_len_bad = (rc_q != RC_W'(nc_q));
            phase_d        = PH_QUAL;
          end
        end
        default: begin
          qfin = 1'b1;
        end
      endcase
    end else begin
      go = 1'b1;
      if (start_q) begin
        start_d = 1'b0;
        if (phase_q == PH_NAME) begin
          go = 1'b0;
          if (data_byte_i != CHAR_AT) begin
            err_d = ERR_NO_AT;
            pl    = add_item(pl, end_item(ERR_NO_AT));
          end
        end else if (phase_q == PH_PLUS) begin
          go = 1'b0;
          if (data_byte_i != CHAR_PLUS) begin
            err_d = ERR_NO_PLUS;
            pl    = add_item(pl, end_item(ERR_NO_PLUS));
          end
        end
      end
      held_d = 1'b0;
      for (int k = 0; k < 2; k++) begin
        if (k == 0) begin
          act = held_q;
          ch  = CHAR_CR7;
        end else begin
          act = go && !stop && (c7 != CHAR_CR7);
          ch  = c7;
        end
        if (act) begin
          case (phase_q)
            PH_NAME: begin
              if (nc_d >= NC_W'(NAME_BYTES)) begin
                err_d = ERR_CAPACITY;
                pl    = add_item(pl, end_item(ERR_CAPACITY));
                stop  = 1'b1;
              end else begin
                if (k == 1) begin
                  req.we    = 1'b1;
                  req.waddr = nc_d[NAME_AW-1:0];
                  req.wdata = ch;
                end
                nc_d = nc_d + NC_W'(1);
                pl   = add_item(pl, byte_item(KIND_NAME, ch));
              end
            end
            PH_SEQ: begin
              if (&seq_d) begin
                err_d = ERR_CAPACITY;
                pl    = add_item(pl, end_item(ERR_CAPACITY));
                stop  = 1'b1;
              end else begin
                seq_d = seq_d + LENGTH_BITS'(1);
                pl    = add_item(pl, byte_item(KIND_SEQ, ch));
              end
            end
            PH_PLUS: begin
              if (k == 0) begin
                pl.use_cr = 1'b1;
              end else begin
                req.re      = 1'b1;
                req.raddr   = rc_d[NAME_AW-1:0];
                pl.cmp_en   = 1'b1;
                pl.cmp_byte = ch;
                pl.cmp_ok   = (rc_d < RC_W'(nc_d));
              end
              if (rc_d <= RC_W'(NAME_BYTES)) begin
                rc_d = rc_d + RC_W'(1);
              end
            end
            default: begin
              if (&qual_d) begin
                err_d = ERR_CAPACITY;
                pl    = add_item(pl, end_item(ERR_CAPACITY));
                stop  = 1'b1;
              end else begin
                qual_d = qual_d + LENGTH_BITS'(1);
                pl     = add_item(pl, byte_item(KIND_QUAL, ch));
              end
            end
          endcase
        end
      end
      // hold CR: park it in the store ahead of time, or probe the name byte it would meet
      if (go && !stop && (c7 == CHAR_CR7)) begin
        held_d = 1'b1;
        if (phase_q == PH_NAME && nc_d < NC_W'(NAME_BYTES)) begin
          req.we    = 1'b1;
          req.waddr = nc_d[NAME_AW-1:0];
          req.wdata = CHAR_CR7;
        end else if (phase_q == PH_PLUS) begin
          req.re      = 1'b1;
          req.raddr   = rc_d[NAME_AW-1:0];
          pl.probe_en = 1'b1;
          pl.probe_ok = (rc_d < RC_W'(nc_d));
        end
      end
    end
    if (qfin) begin
      start_d = 1'b1;
      held_d  = 1'b0;
      if (qual_q != seq_q) begin
        err_d = ERR_LEN_MISMATCH;
        pl    = add_item(pl, end_item(ERR_LEN_MISMATCH));
      end else begin
        pl         = add_item(pl, rec_item(seq_q, rc_q != '0));
        pl.clr_mis = 1'b1;
        phase_d    = PH_NAME;
        nc_d       = '0;
        rc_d       = '0;
        seq_d      = '0;
        qual_d     = '0;
        if (end_of_file_i) begin
          pl = add_item(pl, end_item(ERR_NONE));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_NAME;
      start_q    <= 1'b1;
      held_q     <= 1'b0;
      nc_q       <= '0;
      rc_q       <= '0;
      seq_q      <= '0;
      qual_q     <= '0;
      err_q      <= ERR_NONE;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        phase_q <= phase_d;
        start_q <= start_d;
        held_q  <= held_d;
        nc_q    <= nc_d;
        rc_q    <= rc_d;
        seq_q   <= seq_d;
        qual_q  <= qual_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      plan_q <= pl;
    end
  end

  always_comb begin
    ram_req_o    = req;
    ram_req_o.we = req.we & accept;
    ram_req_o.re = req.re & accept;
  end

  assign s1_valid_o = s1_valid_q;
  assign plan_o     = plan_q;

endmodule

// ===== design/frsp_check.sv =====
// Second-header compare against the name store and the resulting sticky mismatch error.
module frsp_check
  import frsp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s1_valid_i,
  input  plan_t      plan_i,
  input  logic [6:0] rdata_i,
  output logic       push_o,
  output entry_t     entry_o
);

  logic mis_q, crmis_q, sticky3_q;
  logic mis_next, cmp_mis, err3;

  assign cmp_mis  = plan_i.cmp_en & (~plan_i.cmp_ok | (rdata_i != plan_i.cmp_byte));
  assign mis_next = mis_q | (plan_i.use_cr & crmis_q) | cmp_mis;
  assign err3     = plan_i.chk_hdr & plan_i.hdr_rep & (mis_q | plan_i.hdr_len_bad);

  always_comb begin
    entry_o = '0;
    if (sticky3_q || err3) begin
      entry_o.two   = 1'b0;
      entry_o.item0 = end_item(ERR_HDR_MISMATCH);
      push_o        = s1_valid_i;
    end else begin
      entry_o.two   = (plan_i.cnt == 2'd2);
      entry_o.item0 = plan_i.item0;
      entry_o.item1 = plan_i.item1;
      push_o        = s1_valid_i & (plan_i.cnt != 2'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mis_q     <= 1'b0;
      crmis_q   <= 1'b0;
      sticky3_q <= 1'b0;
    end else if (s1_valid_i) begin
      mis_q     <= plan_i.clr_mis ? 1'b0 : mis_next;
      sticky3_q <= sticky3_q | err3;
      if (plan_i.probe_en) begin
        crmis_q <= ~plan_i.probe_ok | (rdata_i != CHAR_CR7);
      end
    end
  end

endmodule

// ===== design/frsp_out_fifo.sv =====
// Result queue: an entry per input with items; one item per unstalled cycle.
module frsp_out_fifo
  import frsp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  entry_t            entry_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output item_t             item_o,
  output logic              last_o,
  output logic [OUT_CW-1:0] count_o
);

  entry_t            mem [OUT_DEPTH];
  entry_t            head;
  logic [OUT_PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_CW-1:0] cnt_q;
  logic              sub_q;
  logic              adv, pop;

  assign head        = mem[rd_ptr_q];
  assign out_valid_o = (cnt_q != '0);
  assign item_o      = sub_q ? head.item1 : head.item0;
  assign last_o      = ~head.two | sub_q;
  assign adv         = out_valid_o & ~out_stall_i;
  assign pop         = adv & last_o;
  assign count_o     = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      sub_q    <= 1'b0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OUT_PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OUT_PW'(1);
      end
      if (adv) begin
        sub_q <= ~last_o;
      end
      cnt_q <= cnt_q + OUT_CW'(push_i) - OUT_CW'(pop);
    end
  end

endmodule

// ===== design/fastq_record_stream_parser_unit.sv =====
// FASTQ record stream parser top level: line walker, name store, header check, result queue.
//
// Input channel: one transaction per text byte (data_byte_i) or an end-of-file marker
// (end_of_file_i). Output channel: one transaction per result item: name, sequence or
// quality byte, record end with sequence length, or stream end / error with a code.
// last_of_run_o marks the final item caused by one input transaction.
// A transaction's first item is registered in the parse stage, then queued, then offered.
// Throughput: one input transaction per cycle while each one yields at most one item and
// the receiver does not stall; unstalled, the output drains one item per cycle, so
// transactions that yield two items (a held CR released with the next byte, or record end
// followed by stream end) slow the input to the output rate. The name store has one write
// port and one registered read port; its compare result lands one stage after the input.
// Reset: returns to the start of a record with no error; the queue empties and name
// store contents are left as they are (only bytes of the current record are compared).
// Receiver stall: up to four transactions' results wait in the queue; in_stall_o rises
// when the queue plus the transaction in flight could not take one more.
// Errors are sticky: after one, every transaction yields one error item until reset.
module fastq_record_stream_parser_unit
  import frsp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   end_of_file_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             item_kind_o,
  output logic [6:0]             payload_byte_o,
  output logic [LENGTH_BITS-1:0] sequence_length_o,
  output logic                   second_header_present_o,
  output logic [2:0]             error_code_o,
  output logic                   last_of_run_o
);

  ram_req_t          ram_req;
  logic [6:0]        rdata;
  logic              s1_valid;
  plan_t             plan;
  logic              push;
  entry_t            entry;
  item_t             item;
  logic [OUT_CW-1:0] count;

  assign in_stall_o = (({1'b0, count} + (OUT_CW + 1)'(s1_valid)) >= (OUT_CW + 1)'(OUT_DEPTH));

  frsp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .end_of_file_i(end_of_file_i),
    .ram_req_o    (ram_req),
    .s1_valid_o   (s1_valid),
    .plan_o       (plan)
  );

  frsp_name_ram u_name_ram (
    .clk_i  (clk_i),
    .req_i  (ram_req),
    .rdata_o(rdata)
  );

  frsp_check u_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s1_valid_i(s1_valid),
    .plan_i    (plan),
    .rdata_i   (rdata),
    .push_o    (push),
    .entry_o   (entry)
  );

  frsp_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .entry_i    (entry),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .item_o     (item),
    .last_o     (last_of_run_o),
    .count_o    (count)
  );

  assign item_kind_o             = item.kind;
  assign payload_byte_o          = item.payload;
  assign sequence_length_o       = item.seq_len;
  assign second_header_present_o = item.hdr;
  assign error_code_o            = item.err;

endmodule

// ===== design/frsp_checker.sv =====
// Port-level checks on the parser's output transactions, bound to the top level.
module frsp_checker
  import frsp_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [2:0]             item_kind_o,
  input logic [6:0]             payload_byte_o,
  input logic [LENGTH_BITS-1:0] sequence_length_o,
  input logic                   second_header_present_o,
  input logic [2:0]             error_code_o,
  input logic                   last_of_run_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(item_kind_o) &&
      $stable(payload_byte_o) && $stable(sequence_length_o) &&
      $stable(error_code_o) && $stable(last_of_run_o))
    else $error("output transaction changed while stalled");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != ERR_NONE |->
      item_kind_o == KIND_STREAM_END && last_of_run_o)
    else $error("error code on a non-final or non-stream-end item");

  a_len_only_rec_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o != KIND_REC_END |->
      sequence_length_o == '0 && !second_header_present_o)
    else $error("record fields set outside a record end");

  a_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o >= KIND_REC_END |->
      item_kind_o <= KIND_STREAM_END && payload_byte_o == 7'd0)
    else $error("payload on a record or stream end, or bad kind");

endmodule

bind fastq_record_stream_parser_unit frsp_checker u_frsp_checker (.*);
